### hw/rtl/move_to_distance_speed_profiler_unit_macros.svh
// Assertion macros for the move-to-distance speed profiler.
// Included by the RTL files that carry concurrent assertions.
`ifndef MOVE_TO_DISTANCE_SPEED_PROFILER_UNIT_MACROS_SVH
`define MOVE_TO_DISTANCE_SPEED_PROFILER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MTDSP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("mtdsp assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define MTDSP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("mtdsp implication failed");

// Check that a condition implies a consequence in the next cycle.
`define MTDSP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("mtdsp next-cycle implication failed");

`endif

### hw/rtl/mtdsp_pkg.sv
// Shared types, codes and constants of the move-to-distance speed profiler.
// No dependencies; used by mtdsp_div and the top level.
package mtdsp_pkg;

  localparam int unsigned MAX_RUN_TICKS_DEF = 100;
  localparam int unsigned BRAKE_TICKS_DEF   = 20;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned REL_W   = 17;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned PROD_W  = 23;
  localparam int unsigned CHK_W   = 24;
  localparam int unsigned NUM_W   = 28;
  localparam int unsigned DIVN_W  = NUM_W - 1;
  localparam int unsigned TGT_W   = 15;
  localparam int unsigned SPD_W   = 10;
  localparam int unsigned LA_W    = 4;
  localparam int unsigned RUN_W   = 7;
  localparam int unsigned BRAKE_W = 5;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 15;

  localparam logic [TGT_W-1:0] TARGET_RST   = TGT_W'(1000);
  localparam logic [SPD_W-1:0] SPEED_RST    = SPD_W'(300);
  localparam logic [LA_W-1:0]  LA_FWD_RST   = LA_W'(8);
  localparam logic [LA_W-1:0]  LA_REV_RST   = LA_W'(8);

  localparam logic [SPD_W-1:0] SPEED_SLOW_FWD = SPD_W'(100);
  localparam logic [SPD_W-1:0] SPEED_SLOW_REV = SPD_W'(50);
  localparam logic [SPD_W-1:0] SPEED_FLOOR    = SPD_W'(99);
  localparam logic [SPD_W-1:0] SPEED_MAX      = SPD_W'(1023);
  localparam logic [POS_W-1:0] REPORT_OFFSET  = POS_W'(5000);

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_FWD   = 2'd1,
    REQ_REV   = 2'd2,
    REQ_ABORT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_FWD   = 2'd1,
    MODE_REV   = 2'd2,
    MODE_BRAKE = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_SPEED  = 2'd1,
    CFG_LA_FWD = 2'd2,
    CFG_LA_REV = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RUN   = 2'd1,
    PH_BRAKE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE = 3'd0,
    SQ_PREP = 3'd1,
    SQ_MUL  = 3'd2,
    SQ_CHK  = 3'd3,
    SQ_DIV  = 3'd4,
    SQ_DONE = 3'd5
  } seq_e;

  typedef struct packed {
    req_e                    request;
    logic signed [POS_W-1:0] encoder_position;
  } in_item_t;

  typedef struct packed {
    mode_e             drive_mode;
    logic [SPD_W-1:0]  drive_speed;
    logic [POS_W-1:0]  position_report;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_stat_t;

endpackage

### hw/rtl/mtdsp_div.sv
// Iterative restoring divider for the speed quotient, one subtract a cycle.
// Flags quotients of 1024 and above as saturated. Depends on mtdsp_pkg.
module mtdsp_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mtdsp_pkg::DIVN_W-1:0]    num_i,
  input  logic [mtdsp_pkg::TGT_W-1:0]     den_i,
  output mtdsp_pkg::div_stat_t            stat_o,
  output logic [mtdsp_pkg::SPD_W-1:0]     quot_o
);
  import mtdsp_pkg::*;

  localparam logic [STEP_W-1:0] StepTop = STEP_W'(SPD_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                sat_q, sat_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [DIVN_W-1:0]   rem_q, rem_d;
  logic [TGT_W-1:0]    den_q, den_d;
  logic [SPD_W-1:0]    quot_q, quot_d;
  logic [DIVN_W-1:0]   shifted;
  logic [DIVN_W:0]     diff;
  logic                ge;

  assign shifted = {{(DIVN_W-TGT_W){1'b0}}, den_q} << step_q;
  assign diff    = {1'b0, rem_q} - {1'b0, shifted};
  assign ge      = !diff[DIVN_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sat_d  = sat_q;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      sat_d  = 1'b0;
      step_d = StepTop;
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      if (step_q == StepTop) begin
        if (ge) begin
          sat_d  = 1'b1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end else begin
        quot_d = {quot_q[SPD_W-2:0], ge};
        if (ge) begin
          rem_d = diff[DIVN_W-1:0];
        end
        if (step_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q  <= sat_d;
    step_q <= step_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.sat  = sat_q;
  assign quot_o      = quot_q;

endmodule

### hw/rtl/move_to_distance_speed_profiler_unit.sv
// Idle, brake and abort ticks pass through PREP and DONE; a run tick that needs no division
// also passes MUL and CHK, and one that divides adds DIV, where it waits for the divider.
// One transaction at a time: the next is taken the cycle after the result is registered;
// the 11-step divider sets the longest transaction. Input is stalled while busy.
// Reset clears configuration to defaults, the profile to idle and the output valid flag.
module move_to_distance_speed_profiler_unit #(
  parameter int unsigned MaxRunTicks = mtdsp_pkg::MAX_RUN_TICKS_DEF,
  parameter int unsigned BrakeTicks  = mtdsp_pkg::BRAKE_TICKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mtdsp_pkg::in_item_t                in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output mtdsp_pkg::out_item_t               out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mtdsp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mtdsp_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import mtdsp_pkg::*;

`include "move_to_distance_speed_profiler_unit_macros.svh"

  localparam logic [RUN_W-1:0]   RunLoad   = RUN_W'(MaxRunTicks);
  localparam logic [BRAKE_W-1:0] BrakeLoad = BRAKE_W'(BrakeTicks - 1);

  logic [TGT_W-1:0] target_q;
  logic [SPD_W-1:0] speed_q;
  logic [LA_W-1:0]  la_fwd_q;
  logic [LA_W-1:0]  la_rev_q;

  seq_e                     state_q, state_d;
  phase_e                   phase_q, phase_d;
  logic                     rev_q, rev_d;
  logic [POS_W-1:0]         base_q, base_d;
  logic signed [REL_W-1:0]  prev_q, prev_d;
  logic [RUN_W-1:0]         run_q, run_d;
  logic [BRAKE_W-1:0]       brake_q, brake_d;
  logic                     out_valid_q, out_valid_d;

  in_item_t                 item_q, item_d;
  out_item_t                res_q, res_d;
  out_item_t                out_q, out_d;
  logic signed [DIST_W-1:0] dist_q, dist_d;
  logic signed [DIST_W-1:0] travel_q, travel_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [NUM_W-1:0]  num_q, num_d;

  logic                     in_acc;
  logic                     out_free;
  logic                     is_start;
  logic                     is_abort;
  req_e                     own_req;
  logic                     rev_n;
  logic [POS_W-1:0]         raw;
  logic [POS_W-1:0]         base_n;
  logic signed [REL_W-1:0]  prev_n;
  logic signed [REL_W-1:0]  rel;
  logic signed [DIST_W-1:0] rel_x;
  logic signed [DIST_W-1:0] prev_x;
  logic signed [DIST_W-1:0] tgt_x;
  logic [LA_W-1:0]          la_sel;
  logic signed [PROD_W-1:0] la_ext;
  logic signed [PROD_W-1:0] travel_ext;
  logic signed [NUM_W-1:0]  spd_ext;
  logic signed [NUM_W-1:0]  dist_ext;
  logic signed [CHK_W-1:0]  margin;
  logic                     go;
  logic                     num_pos;
  logic [BRAKE_W-1:0]       brake_dec;
  logic [SPD_W-1:0]         slow_speed;
  logic                     div_start;
  div_stat_t                div_stat;
  logic [SPD_W-1:0]         div_quot;

  assign in_stall_o  = (state_q != SQ_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      speed_q  <= SPEED_RST;
      la_fwd_q <= LA_FWD_RST;
      la_rev_q <= LA_REV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET: target_q <= cfg_data_i[TGT_W-1:0];
        CFG_SPEED:  speed_q  <= cfg_data_i[SPD_W-1:0];
        CFG_LA_FWD: la_fwd_q <= cfg_data_i[LA_W-1:0];
        CFG_LA_REV: la_rev_q <= cfg_data_i[LA_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick decode and relative position
  always_comb begin
    raw      = item_q.encoder_position;
    is_start = (phase_q == PH_IDLE) &&
               ((item_q.request == REQ_FWD) || (item_q.request == REQ_REV));
    own_req  = rev_q ? REQ_REV : REQ_FWD;
    is_abort = (phase_q == PH_RUN) && (item_q.request != REQ_NONE) &&
               (item_q.request != own_req);
    rev_n    = is_start ? (item_q.request == REQ_REV) : rev_q;
    base_n   = is_start ? raw : base_q;
    prev_n   = is_start ? '0 : prev_q;
    rel      = $signed({raw[POS_W-1], raw}) - $signed({base_n[POS_W-1], base_n});
    rel_x    = {rel[REL_W-1], rel};
    prev_x   = {prev_n[REL_W-1], prev_n};
    tgt_x    = $signed({{(DIST_W-TGT_W){1'b0}}, target_q});
    la_sel   = rev_q ? la_rev_q : la_fwd_q;
    la_ext   = $signed({{(PROD_W-LA_W){1'b0}}, la_sel});
    travel_ext = {{(PROD_W-DIST_W){travel_q[DIST_W-1]}}, travel_q};
    spd_ext  = $signed({{(NUM_W-SPD_W){1'b0}}, speed_q});
    dist_ext = {{(NUM_W-DIST_W){dist_q[DIST_W-1]}}, dist_q};
    margin   = {{(CHK_W-DIST_W){dist_q[DIST_W-1]}}, dist_q} -
               {{(CHK_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    go       = !margin[CHK_W-1] && (margin != '0);
    num_pos  = !num_q[NUM_W-1] && (num_q != '0);
    brake_dec  = brake_q - BRAKE_W'(brake_q != '0);
    slow_speed = rev_q ? SPEED_SLOW_REV : SPEED_SLOW_FWD;
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    rev_d       = rev_q;
    base_d      = base_q;
    prev_d      = prev_q;
    run_d       = run_q;
    brake_d     = brake_q;
    item_d      = item_q;
    res_d       = res_q;
    dist_d      = dist_q;
    travel_d    = travel_q;
    prod_d      = prod_q;
    num_d       = num_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    div_start   = 1'b0;

    unique case (state_q)
      SQ_IDLE: begin
        if (in_acc) begin
          item_d  = in_data_i;
          state_d = SQ_PREP;
        end
      end
      SQ_PREP: begin
        rev_d  = rev_n;
        base_d = base_n;
        res_d.position_report = REPORT_OFFSET + raw - base_n;
        res_d.drive_speed     = '0;
        dist_d   = rev_n ? (tgt_x + rel_x) : (tgt_x - rel_x);
        travel_d = rev_n ? (prev_x - rel_x) : (rel_x - prev_x);
        state_d  = SQ_DONE;
        if (is_abort) begin
          res_d.drive_mode = MODE_BRAKE;
          brake_d = BrakeLoad;
          phase_d = (BrakeLoad == '0) ? PH_IDLE : PH_BRAKE;
        end else if (is_start || (phase_q == PH_RUN)) begin
          phase_d = PH_RUN;
          prev_d  = rel;
          if (is_start) begin
            run_d = RunLoad;
          end
          state_d = SQ_MUL;
        end else if (phase_q == PH_BRAKE) begin
          res_d.drive_mode = MODE_BRAKE;
          brake_d = brake_dec;
          if (brake_dec == '0) begin
            phase_d = PH_IDLE;
          end
        end else begin
          res_d.drive_mode = MODE_NONE;
        end
      end
      SQ_MUL: begin
        prod_d  = la_ext * travel_ext;
        num_d   = spd_ext * dist_ext;
        state_d = SQ_CHK;
      end
      SQ_CHK: begin
        state_d = SQ_DONE;
        if (go && (run_q != '0)) begin
          run_d = run_q - RUN_W'(1);
          res_d.drive_mode = rev_q ? MODE_REV : MODE_FWD;
          if (!num_pos) begin
            res_d.drive_speed = slow_speed;
          end else if (target_q == '0) begin
            res_d.drive_speed = SPEED_MAX;
          end else begin
            div_start = 1'b1;
            state_d   = SQ_DIV;
          end
        end else begin
          res_d.drive_mode = MODE_BRAKE;
          brake_d = BrakeLoad;
          phase_d = (BrakeLoad == '0) ? PH_IDLE : PH_BRAKE;
        end
      end
      SQ_DIV: begin
        if (div_stat.done) begin
          if (div_stat.sat) begin
            res_d.drive_speed = SPEED_MAX;
          end else if (div_quot <= SPEED_FLOOR) begin
            res_d.drive_speed = slow_speed;
          end else begin
            res_d.drive_speed = div_quot;
          end
          state_d = SQ_DONE;
        end
      end
      SQ_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = SQ_IDLE;
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      phase_q     <= PH_IDLE;
      rev_q       <= 1'b0;
      base_q      <= '0;
      prev_q      <= '0;
      run_q       <= '0;
      brake_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      rev_q       <= rev_d;
      base_q      <= base_d;
      prev_q      <= prev_d;
      run_q       <= run_d;
      brake_q     <= brake_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    res_q    <= res_d;
    out_q    <= out_d;
    dist_q   <= dist_d;
    travel_q <= travel_d;
    prod_q   <= prod_d;
    num_q    <= num_d;
  end

  mtdsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q[DIVN_W-1:0]),
    .den_i  (target_q),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  `MTDSP_ASSERT_IMP(a_div_done_in_div, clk_i, rst_ni, div_stat.done, state_q == SQ_DIV)
  `MTDSP_ASSERT_IMP(a_brake_count_live, clk_i, rst_ni, phase_q == PH_BRAKE, brake_q != '0)
  `MTDSP_ASSERT_IMP(a_drive_has_speed, clk_i, rst_ni, out_valid_q && (out_q.drive_mode == MODE_FWD || out_q.drive_mode == MODE_REV), out_q.drive_speed >= SPEED_SLOW_REV)
  `MTDSP_ASSERT_IMP(a_stop_zero_speed, clk_i, rst_ni, out_valid_q && (out_q.drive_mode == MODE_BRAKE || out_q.drive_mode == MODE_NONE), out_q.drive_speed == '0)
  `MTDSP_ASSERT_NXT(a_accept_to_prep, clk_i, rst_ni, in_acc, state_q == SQ_PREP)

endmodule

### sim/move_to_distance_speed_profiler_unit_tb.sv
// Self-checking testbench for move_to_distance_speed_profiler_unit: predicts every
// drive command per control tick and compares it field by field.
// Depends on mtdsp_pkg and the profiler RTL only.
`timescale 1ns / 100ps

module move_to_distance_speed_profiler_unit_tb;
  import mtdsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned MAX_GAP     = 17;

  class drive_command_board;
    logic [TGT_W-1:0] target;
    logic [SPD_W-1:0] top_speed;
    logic [LA_W-1:0]  ahead_fwd;
    logic [LA_W-1:0]  ahead_rev;
    phase_e           phase;
    bit               reverse;
    logic [POS_W-1:0] base;
    int               last_rel;
    int               run_left;
    int               brake_left;
    out_item_t        pending_cmds[$];
    int               errors;
    int               results;

    function new();
      target     = TARGET_RST;
      top_speed  = SPEED_RST;
      ahead_fwd  = LA_FWD_RST;
      ahead_rev  = LA_REV_RST;
      phase      = PH_IDLE;
      reverse    = 1'b0;
      base       = '0;
      last_rel   = 0;
      run_left   = 0;
      brake_left = 0;
      errors     = 0;
      results    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        CFG_TARGET: target    = val[TGT_W-1:0];
        CFG_SPEED:  top_speed = val[SPD_W-1:0];
        CFG_LA_FWD: ahead_fwd = val[LA_W-1:0];
        CFG_LA_REV: ahead_rev = val[LA_W-1:0];
        default: ;
      endcase
    endfunction

    function int scaled_speed(longint remain, bit rev_dir);
      longint num;
      longint q;
      num = longint'(top_speed) * remain;
      if (num <= 0) return rev_dir ? int'(SPEED_SLOW_REV) : int'(SPEED_SLOW_FWD);
      if (target == 0) return int'(SPEED_MAX);
      q = num / longint'(target);
      if (q <= longint'(SPEED_FLOOR)) return rev_dir ? int'(SPEED_SLOW_REV) : int'(SPEED_SLOW_FWD);
      if (q > longint'(SPEED_MAX)) return int'(SPEED_MAX);
      return int'(q);
    endfunction

    function void begin_brake();
      brake_left = BRAKE_TICKS_DEF - 1;
      phase = (brake_left == 0) ? PH_IDLE : PH_BRAKE;
    endfunction

    function void take_tick(in_item_t tick);
      req_e             rq;
      logic [POS_W-1:0] raw;
      mode_e            mode;
      int               speed;
      int               rel;
      longint           r;
      longint           p;
      longint           tgt;
      bit               go;
      out_item_t        cmd;
      rq    = tick.request;
      raw   = tick.encoder_position;
      mode  = MODE_NONE;
      speed = 0;
      if (phase == PH_IDLE && (rq == REQ_FWD || rq == REQ_REV)) begin
        phase    = PH_RUN;
        reverse  = (rq == REQ_REV);
        base     = raw;
        last_rel = 0;
        run_left = MAX_RUN_TICKS_DEF;
      end else if (phase == PH_RUN && rq != REQ_NONE && rq != (reverse ? REQ_REV : REQ_FWD)) begin
        begin_brake();
        mode = MODE_BRAKE;
      end
      rel = int'($signed(raw)) - int'($signed(base));
      if (phase == PH_RUN) begin
        r   = rel;
        p   = last_rel;
        tgt = target;
        if (!reverse) go = tgt > r + longint'(ahead_fwd) * (r - p);
        else go = longint'(ahead_rev) * (p - r) < r + tgt;
        last_rel = rel;
        if (go && run_left != 0) begin
          run_left--;
          mode  = reverse ? MODE_REV : MODE_FWD;
          speed = reverse ? scaled_speed(tgt + r, 1'b1) : scaled_speed(tgt - r, 1'b0);
        end else begin
          begin_brake();
          mode = MODE_BRAKE;
        end
      end else if (phase == PH_BRAKE && mode == MODE_NONE) begin
        mode = MODE_BRAKE;
        if (brake_left > 0) brake_left--;
        if (brake_left == 0) phase = PH_IDLE;
      end
      cmd.drive_mode      = mode;
      cmd.drive_speed     = SPD_W'(speed);
      cmd.position_report = REPORT_OFFSET + raw - base;
      pending_cmds.push_back(cmd);
    endfunction

    task flag(string what);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_command(out_item_t got);
      out_item_t want;
      results++;
      if (pending_cmds.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing pending", results));
        return;
      end
      want = pending_cmds.pop_front();
      if (got.drive_mode !== want.drive_mode)
        flag($sformatf("result %0d drive_mode %0d, want %0d", results, got.drive_mode,
                       want.drive_mode));
      if (got.drive_speed !== want.drive_speed)
        flag($sformatf("result %0d drive_speed %0d, want %0d", results, got.drive_speed,
                       want.drive_speed));
      if (got.position_report !== want.position_report)
        flag($sformatf("result %0d position_report %0d, want %0d", results,
                       got.position_report, want.position_report));
    endtask

    function int pending();
      return pending_cmds.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  drive_command_board board = new();
  bit                 calm = 1'b0;
  int                 span = TARGET_RST;
  int                 items_sent = 0;

  move_to_distance_speed_profiler_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_reg(cfg_idx_e'(cfg_index), cfg_data);
      if (in_valid && !in_stall) board.take_tick(in_data);
      if (out_valid === 1'b1 && !out_stall) board.check_command(out_data);
    end
  end

  initial begin
    int unsigned hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[move_to_distance_speed_profiler_unit] ERROR");
    $finish;
  end

  task send_tick(req_e rq, logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rq, pos};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task load_settings(int tgt, int spd, int laf, int lar);
    logic [CFG_DAT_W-1:0] junk;
    span = tgt;
    junk = CFG_DAT_W'($urandom);
    write_reg(CFG_TARGET, CFG_DAT_W'(tgt));
    write_reg(CFG_SPEED, {junk[CFG_DAT_W-1:SPD_W], SPD_W'(spd)});
    junk = CFG_DAT_W'($urandom);
    write_reg(CFG_LA_FWD, {junk[CFG_DAT_W-1:LA_W], LA_W'(laf)});
    junk = CFG_DAT_W'($urandom);
    write_reg(CFG_LA_REV, {junk[CFG_DAT_W-1:LA_W], LA_W'(lar)});
    cfg_valid <= 1'b0;
  endtask

  task run_move();
    bit   rv;
    req_e own;
    req_e rq;
    int   pos;
    int   k;
    int   step;
    int   jit;
    int   delta;
    rv   = $urandom_range(0, 1);
    own  = rv ? REQ_REV : REQ_FWD;
    pos  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                       : int'($urandom_range(0, 40000)) - 20000;
    k    = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 110) : $urandom_range(2, 40);
    step = span / k;
    if (step < 1) step = 1;
    jit  = step / 4;
    send_tick(own, POS_W'(pos));
    repeat (k + 4 + BRAKE_TICKS_DEF) begin
      delta = step + int'($urandom_range(0, 2 * jit)) - jit;
      if ($urandom_range(0, 15) == 0) delta = -delta;
      pos = rv ? pos - delta : pos + delta;
      case ($urandom_range(0, 63))
        0: rq = REQ_ABORT;
        1: rq = rv ? REQ_FWD : REQ_REV;
        2: rq = own;
        default: rq = REQ_NONE;
      endcase
      send_tick(rq, POS_W'(pos));
    end
  endtask

  task noise_burst();
    repeat ($urandom_range(1, 8)) send_tick(req_e'($urandom_range(0, 3)), POS_W'($urandom));
  endtask

  initial begin
    int goal;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // ignored abort, start at the top of the range, wrap to the bottom, repeat start, reverse
    send_tick(REQ_ABORT, 16'h7FFF);
    send_tick(REQ_NONE, 16'h8000);
    send_tick(REQ_FWD, 16'h7FFF);
    send_tick(REQ_NONE, 16'h8000);
    send_tick(REQ_FWD, 16'h8010);
    send_tick(REQ_REV, 16'h0000);
    // requests while braking
    send_tick(REQ_FWD, 16'hFFFF);
    send_tick(REQ_REV, 16'h0001);
    send_tick(REQ_ABORT, 16'h5555);
    repeat (16) send_tick(REQ_NONE, POS_W'($urandom));
    send_tick(REQ_REV, 16'hAAAA);
    send_tick(REQ_ABORT, 16'hAA00);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_settings(1, 1023, 0, 15);
        1: load_settings(32767, 0, 15, 0);
        2: load_settings(0, 600, 3, 3);
        3: load_settings(32767, 1023, 0, 0);
        4: load_settings(1, 0, 15, 15);
        default: load_settings(($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767)
                                                           : $urandom_range(1, 3000),
                               $urandom_range(0, 1023), $urandom_range(0, 15),
                               $urandom_range(0, 15));
      endcase
      calm = ($urandom_range(0, 3) == 0);
      goal = items_sent + 142;
      while (items_sent < goal) begin
        if ($urandom_range(0, 9) < 7) run_move();
        else noise_burst();
      end
      wait_drained();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("[move_to_distance_speed_profiler_unit] OK");
    end else begin
      $display("[move_to_distance_speed_profiler_unit] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/mtdsp_pkg.sv
hw/rtl/mtdsp_div.sv
hw/rtl/move_to_distance_speed_profiler_unit.sv
sim/move_to_distance_speed_profiler_unit_tb.sv
